### rtl/variable_length_code_bit_packer_defines.svh
// assertion macros for the variable length code bit packer
// used by the top level only, expects clk and rst_n in scope
`ifndef VARIABLE_LENGTH_CODE_BIT_PACKER_DEFINES_SVH
`define VARIABLE_LENGTH_CODE_BIT_PACKER_DEFINES_SVH

// same-cycle implication
`define VLCBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VLCBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vlcbp_pkg.sv
// shared types, command codes and constants of the bit packer
// no dependencies
package vlcbp_pkg;

  localparam int DEF_VALUE_WIDTH = 64;
  localparam int VALUE_FIELD_W   = 64;
  localparam int CNT_W           = 7;
  localparam int CMD_W           = 2;
  localparam int IN_DATA_W       = ((VALUE_FIELD_W + CNT_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_RAW   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_VBYTE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ELIAS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd3;

  localparam logic [3:0] BYTE_BITS  = 4'd8;
  localparam int         GROUP_BITS = 7;
  localparam logic [7:0] GROUP_MASK = 8'h7f;
  localparam logic [7:0] STOP_FLAG  = 8'h80;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALIGN,
    S_RAW_EMIT,
    S_VB_LOAD,
    S_VB_EMIT,
    S_ED_NORM,
    S_ED_HDR,
    S_ED_DROP,
    S_ED_TAIL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic ready;
    logic align;
    logic emit;
    logic emit_hdr;
    logic vb_load;
    logic norm;
    logic drop;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             start_empty;
    logic             ashift_zero;
    logic             emit_last;
    logic             norm_done;
    logic             last_group;
    logic             tail_empty;
    logic             done_go;
  } stat_t;

endpackage

### rtl/vlcbp_shift.sv
// shared left shifter of the bit packer, amounts 0 to 8
// serves alignment, normalising, dropping and bit emission; uses vlcbp_pkg
module vlcbp_shift #(
  parameter int W = vlcbp_pkg::DEF_VALUE_WIDTH
) (
  input  logic [W-1:0] word,
  input  logic [3:0]   amt,
  output logic [W-1:0] shifted,
  output logic [7:0]   top
);
  import vlcbp_pkg::*;

  always_comb begin
    shifted = (amt > BYTE_BITS) ? '0 : (word << amt);
    top     = word[W-1 -: 8];
  end

endmodule

### rtl/vlcbp_fsm.sv
// sequencer of the bit packer: steps each request through its phases
// uses vlcbp_pkg for state, control and status types
module vlcbp_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  vlcbp_pkg::stat_t  stat,
  output vlcbp_pkg::ctl_t   ctl
);
  import vlcbp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (stat.cmd)
            CMD_RAW:   state_nxt = stat.start_empty ? S_DONE : S_ALIGN;
            CMD_VBYTE: state_nxt = S_VB_LOAD;
            CMD_ELIAS: state_nxt = stat.start_empty ? S_DONE : S_ED_NORM;
            CMD_FLUSH: state_nxt = stat.start_empty ? S_DONE : S_RAW_EMIT;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_ALIGN:    if (stat.ashift_zero) state_nxt = S_RAW_EMIT;
      S_RAW_EMIT: if (stat.emit_last) state_nxt = S_DONE;
      S_VB_LOAD:  state_nxt = S_VB_EMIT;
      S_VB_EMIT: begin
        if (stat.emit_last) state_nxt = stat.last_group ? S_DONE : S_VB_LOAD;
      end
      S_ED_NORM:  if (stat.norm_done) state_nxt = S_ED_HDR;
      S_ED_HDR:   if (stat.emit_last) state_nxt = S_ED_DROP;
      S_ED_DROP:  state_nxt = stat.tail_empty ? S_DONE : S_ED_TAIL;
      S_ED_TAIL:  if (stat.emit_last) state_nxt = S_DONE;
      S_DONE:     if (stat.done_go) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      S_IDLE:     ctl.ready = 1'b1;
      S_ALIGN:    ctl.align = 1'b1;
      S_RAW_EMIT: ctl.emit = 1'b1;
      S_VB_LOAD:  ctl.vb_load = 1'b1;
      S_VB_EMIT: begin
        ctl.emit     = 1'b1;
        ctl.emit_hdr = 1'b1;
      end
      S_ED_NORM:  ctl.norm = 1'b1;
      S_ED_HDR: begin
        ctl.emit     = 1'b1;
        ctl.emit_hdr = 1'b1;
      end
      S_ED_DROP:  ctl.drop = 1'b1;
      S_ED_TAIL:  ctl.emit = 1'b1;
      S_DONE:     ctl.finish = 1'b1;
      default:    ctl = '0;
    endcase
  end

endmodule

### rtl/variable_length_code_bit_packer.sv
// top level of the variable length code bit packer: datapath, byte output stage
// uses vlcbp_pkg, vlcbp_shift, vlcbp_fsm and the assertion macro header
`include "variable_length_code_bit_packer_defines.svh"

// Appends raw bit fields, vbyte groups or Elias delta codes MSB first into a
// byte stream, keeping up to seven bits pending between requests; a flush pads
// the partial byte with zeros. One request is taken at a time and in_tready is
// low while it is worked on. The shared 0..8 bit shifter moves bits into the
// pending byte until it fills, unless a full byte waits on a stalled output.
// A raw request is first aligned by shifting its field to the top of the word
// in steps of up to 8 bits; a vbyte request loads and then emits each 7-bit
// group with its stop flag; an Elias delta request first normalises value+1 to
// find its length, then emits its length prefix and drops the leading one
// before the tail. The last byte of each request is held back in hold_r so
// that it leaves with out_tlast set; a stalled output holds the work.
module variable_length_code_bit_packer #(
  parameter int VALUE_WIDTH = vlcbp_pkg::DEF_VALUE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [vlcbp_pkg::IN_DATA_W-1:0] in_tdata,   // value[63:0], raw_len[70:64], pad
  input  logic [vlcbp_pkg::CMD_W-1:0]    in_tuser,   // command
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // out_byte
  output logic                           out_tlast   // last_of_run
);
  import vlcbp_pkg::*;

  localparam int W   = VALUE_WIDTH;
  localparam int LW  = $clog2(W + 1);
  localparam int HW  = (2 * LW - 1 > 8) ? 2 * LW - 1 : 8;
  localparam int HLW = $clog2(HW + 1);

  ctl_t  ctl;
  stat_t stat;

  logic [7:0]    pend_r, pend_nxt;
  logic [2:0]    pcnt_r, pcnt_nxt;
  logic [W-1:0]  src_r, src_nxt;
  logic [HW-1:0] hdr_r, hdr_nxt;
  logic [LW-1:0] rem_r, rem_nxt;
  logic [LW-1:0] ashift_r, ashift_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          last_group_r, last_group_nxt;
  logic [7:0]    hold_r, hold_nxt;
  logic          hold_v_r, hold_v_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [7:0]    out_tdata_r, out_tdata_nxt;
  logic          out_tlast_r, out_tlast_nxt;

  logic [CMD_W-1:0] cmd;
  logic [W-1:0]     vm;
  logic [CNT_W-1:0] bcnt;
  logic [LW-1:0]    cnt_sat;
  logic             accept;
  logic [3:0]       space;
  logic [LW-1:0]    space_w;
  logic [LW-1:0]    n_w;
  logic [3:0]       n;
  logic [3:0]       fill;
  logic             byte_done;
  logic             slot_free;
  logic             emit_go;
  logic [W-1:0]     op;
  logic [3:0]       amt;
  logic [W-1:0]     sh_word;
  logic [7:0]       top;
  logic [7:0]       chunk;
  logic [7:0]       pend_new;
  logic             vb_stop;
  logic [7:0]       vb_byte;
  logic [HLW-1:0]   hl;
  logic [HW-1:0]    hdr_ed;
  logic             push;
  logic             push_last;

  function automatic logic [HLW-1:0] bit_len(input logic [LW-1:0] x);
    logic [HLW-1:0] b;
    b = '0;
    for (int i = 0; i < LW; i++) begin
      if (x[i]) b = HLW'(i + 1);
    end
    return b;
  endfunction

  vlcbp_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .ctl       (ctl)
  );

  vlcbp_shift #(.W(W)) u_shift (
    .word    (op),
    .amt     (amt),
    .shifted (sh_word),
    .top     (top)
  );

  assign cmd     = in_tuser;
  assign vm      = in_tdata[W-1:0];
  assign bcnt    = in_tdata[VALUE_FIELD_W +: CNT_W];
  assign cnt_sat = (bcnt > CNT_W'(W)) ? LW'(W) : LW'(bcnt);
  assign accept  = in_tvalid && ctl.ready;

  // fill of the pending byte
  assign space     = BYTE_BITS - {1'b0, pcnt_r};
  assign space_w   = LW'(space);
  assign n_w       = (rem_r < space_w) ? rem_r : space_w;
  assign n         = 4'(n_w);
  assign fill      = {1'b0, pcnt_r} + n;
  assign byte_done = (fill == BYTE_BITS);
  assign slot_free = !out_tvalid_r || out_tready;
  assign emit_go   = !(byte_done && hold_v_r && !slot_free);

  assign op       = ctl.emit_hdr ? (W'(hdr_r) << (W - HW)) : src_r;
  assign chunk    = top & ~(8'hff >> n);
  assign pend_new = pend_r | (chunk >> pcnt_r);

  assign vb_stop = ((src_r >> GROUP_BITS) == W'(0));
  assign vb_byte = (vb_stop ? STOP_FLAG : 8'h00) | (8'(src_r[GROUP_BITS-1:0]) & GROUP_MASK);

  assign hl     = HLW'(2) * bit_len(len_r) - HLW'(1);
  assign hdr_ed = HW'(len_r) << (HLW'(HW) - hl);

  always_comb begin
    amt = '0;
    if (ctl.align) begin
      amt = (ashift_r < LW'(BYTE_BITS)) ? 4'(ashift_r) : BYTE_BITS;
    end else if (ctl.emit) begin
      amt = n;
    end else if (ctl.norm) begin
      amt = (top == 8'h00) ? BYTE_BITS : 4'd1;
    end else if (ctl.drop) begin
      amt = 4'd1;
    end
  end

  always_comb begin
    stat             = '0;
    stat.cmd         = cmd;
    unique case (cmd)
      CMD_RAW:   stat.start_empty = (cnt_sat == '0);
      CMD_VBYTE: stat.start_empty = 1'b0;
      CMD_ELIAS: stat.start_empty = &vm;
      CMD_FLUSH: stat.start_empty = (pcnt_r == '0);
      default:   stat.start_empty = 1'b0;
    endcase
    stat.ashift_zero = (ashift_r == '0);
    stat.emit_last   = emit_go && (rem_r <= space_w);
    stat.norm_done   = src_r[W-1];
    stat.last_group  = last_group_r;
    stat.tail_empty  = (len_r == LW'(1));
    stat.done_go     = !hold_v_r || slot_free;
  end

  always_comb begin
    push      = 1'b0;
    push_last = 1'b0;
    if (ctl.emit && emit_go && byte_done && hold_v_r) begin
      push = 1'b1;
    end else if (ctl.finish && hold_v_r && slot_free) begin
      push      = 1'b1;
      push_last = 1'b1;
    end
  end

  always_comb begin
    pend_nxt       = pend_r;
    pcnt_nxt       = pcnt_r;
    src_nxt        = src_r;
    hdr_nxt        = hdr_r;
    rem_nxt        = rem_r;
    ashift_nxt     = ashift_r;
    len_nxt        = len_r;
    last_group_nxt = last_group_r;
    hold_nxt       = hold_r;
    hold_v_nxt     = hold_v_r;

    if (accept) begin
      unique case (cmd)
        CMD_RAW: begin
          src_nxt    = vm;
          rem_nxt    = cnt_sat;
          ashift_nxt = LW'(W) - cnt_sat;
        end
        CMD_VBYTE: src_nxt = vm;
        CMD_ELIAS: begin
          src_nxt = vm + W'(1);
          len_nxt = LW'(W);
        end
        CMD_FLUSH: begin
          src_nxt    = '0;
          rem_nxt    = space_w;
          ashift_nxt = '0;
        end
        default: src_nxt = src_r;
      endcase
    end

    if (ctl.align && !stat.ashift_zero) begin
      src_nxt    = sh_word;
      ashift_nxt = ashift_r - LW'(amt);
    end

    if (ctl.emit && emit_go) begin
      if (ctl.emit_hdr) begin
        hdr_nxt = sh_word[W-1 -: HW];
      end else begin
        src_nxt = sh_word;
      end
      rem_nxt = rem_r - n_w;
      if (byte_done) begin
        pend_nxt   = '0;
        pcnt_nxt   = '0;
        hold_nxt   = pend_new;
        hold_v_nxt = 1'b1;
      end else begin
        pend_nxt = pend_new;
        pcnt_nxt = 3'(fill);
      end
    end

    if (ctl.vb_load) begin
      hdr_nxt        = HW'(vb_byte) << (HW - 8);
      rem_nxt        = LW'(BYTE_BITS);
      src_nxt        = src_r >> GROUP_BITS;
      last_group_nxt = vb_stop;
    end

    if (ctl.norm) begin
      if (src_r[W-1]) begin
        hdr_nxt = hdr_ed;
        rem_nxt = LW'(hl);
      end else begin
        src_nxt = sh_word;
        len_nxt = len_r - LW'(amt);
      end
    end

    if (ctl.drop) begin
      src_nxt = sh_word;
      rem_nxt = len_r - LW'(1);
    end

    if (push_last) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    if (push) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = hold_r;
      out_tlast_nxt  = push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= '0;
      pcnt_r       <= '0;
      hold_v_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      pend_r       <= pend_nxt;
      pcnt_r       <= pcnt_nxt;
      hold_v_r     <= hold_v_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    hdr_r        <= hdr_nxt;
    rem_r        <= rem_nxt;
    ashift_r     <= ashift_nxt;
    len_r        <= len_nxt;
    last_group_r <= last_group_nxt;
    hold_r       <= hold_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tlast_r  <= out_tlast_nxt;
  end

  assign in_tready  = ctl.ready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `VLCBP_ASSERT_IMP(a_idle_no_hold, in_tready, !hold_v_r, "byte still held while idle")
  `VLCBP_ASSERT_IMP(a_emit_has_bits, ctl.emit, rem_r != '0, "emit phase with no bits left")
  `VLCBP_ASSERT_IMP(a_norm_nonzero, ctl.norm, src_r != '0, "normalising a zero word")
  `VLCBP_ASSERT_NXT(a_finish_idle, ctl.finish && stat.done_go, in_tready, "no return to idle")

endmodule
